### rtl/tsp_pkg.sv
// tsp_pkg: shared constants and types for the tlv stream parser
// no dependencies; imported by tsp_parse and tlv_stream_parser_top
`default_nettype none

package tsp_pkg;

  // number of key bytes at the head of each fragment (1 to 16)
  localparam int unsigned KEY_BYTES = 1;

  localparam int unsigned KEY_POS_W = 4;
  localparam int unsigned KIND_W    = 2;

  // index of the last key byte in a fragment
  localparam logic [KEY_POS_W-1:0] KEY_LAST = KEY_POS_W'(KEY_BYTES - 1);

  // byte classes
  localparam logic [KIND_W-1:0] KIND_KEY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VAL = 2'd2;

  // one result transaction
  typedef struct packed {
    logic [7:0]           byte_out;
    logic [KIND_W-1:0]    byte_kind;
    logic [KEY_POS_W-1:0] key_position;
    logic                 fragment_end;
    logic                 message_end;
    logic                 status;
  } tsp_result_t;

endpackage

`default_nettype wire

### rtl/tsp_parse.sv
// tsp_parse: fragment state (phase, key counter, value countdown) and byte classification
// depends on tsp_pkg
`default_nettype none

module tsp_parse import tsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        message_last_i,
  output tsp_result_t      result_o
);

  localparam logic [1:0] PH_KEY = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  logic [1:0]           phase_q, phase_d;
  logic [KEY_POS_W-1:0] key_count_q, key_count_d;
  logic [7:0]           remain_q, remain_d;

  logic [1:0]           ph_next;
  logic [KEY_POS_W-1:0] kc_next;
  logic [7:0]           rem_next;
  logic [KIND_W-1:0]    kind;
  logic [KEY_POS_W-1:0] kpos;
  logic                 frag_end;

  // classify the byte and step the fragment state
  always_comb begin
    ph_next  = phase_q;
    kc_next  = key_count_q;
    rem_next = remain_q;
    kind     = KIND_KEY;
    kpos     = '0;
    frag_end = 1'b0;
    case (phase_q)
      PH_LEN: begin
        kind     = KIND_LEN;
        rem_next = data_byte_i;
        if (data_byte_i == 8'd0) begin
          frag_end = 1'b1;
          ph_next  = PH_KEY;
        end else begin
          ph_next  = PH_VAL;
        end
      end
      PH_VAL: begin
        kind     = KIND_VAL;
        rem_next = remain_q - 8'd1;
        if (rem_next == 8'd0) begin
          frag_end = 1'b1;
          ph_next  = PH_KEY;
        end
      end
      default: begin
        // key phase, and the unused code
        kind = KIND_KEY;
        kpos = key_count_q;
        if (key_count_q >= KEY_LAST) begin
          kc_next = '0;
          ph_next = PH_LEN;
        end else begin
          kc_next = key_count_q + KEY_POS_W'(1);
          ph_next = PH_KEY;
        end
      end
    endcase
  end

  // message end puts the parser back at a fragment start
  always_comb begin
    if (message_last_i) begin
      phase_d     = PH_KEY;
      key_count_d = '0;
      remain_d    = '0;
    end else begin
      phase_d     = ph_next;
      key_count_d = kc_next;
      remain_d    = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KEY;
      key_count_q <= '0;
      remain_q    <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      key_count_q <= key_count_d;
      remain_q    <= remain_d;
    end
  end

  // result fields
  always_comb begin
    result_o.byte_out     = data_byte_i;
    result_o.byte_kind    = kind;
    result_o.key_position = kpos;
    result_o.fragment_end = frag_end;
    result_o.message_end  = message_last_i;
    result_o.status       = message_last_i & ~frag_end;
  end

endmodule

`default_nettype wire

### rtl/tlv_stream_parser_top.sv
// Type-length-value stream parser. Takes one message byte per cycle while in_stall_o
// is low and returns one classified byte per transaction: the byte is captured in an
// input register, classified against the fragment state in tsp_parse, and written to
// a result register, from which it is offered on the output channel. Both registers
// move on in the same cycle, so a new byte is taken every cycle while the result side
// does not stall; in_stall_o rises only when both registers are full and out_stall_i
// holds the result. Each fragment is KEY_BYTES key bytes, a length byte and that many
// value bytes; a message ending mid-fragment reports status 1 on its last byte and the
// parser restarts at a fragment start.
// depends on tsp_pkg and tsp_parse
`default_nettype none

module tlv_stream_parser_top import tsp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 message_last_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                byte_out_o,
  output logic [KIND_W-1:0]         byte_kind_o,
  output logic [KEY_POS_W-1:0]      key_position_o,
  output logic                      fragment_end_o,
  output logic                      message_end_o,
  output logic                      status_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  tsp_result_t res_q;
  tsp_result_t res_d;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // handshake: result register frees when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
      in_last_q <= message_last_i;
    end
  end

  tsp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .data_byte_i    (in_byte_q),
    .message_last_i (in_last_q),
    .result_o       (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = res_q.byte_out;
  assign byte_kind_o    = res_q.byte_kind;
  assign key_position_o = res_q.key_position;
  assign fragment_end_o = res_q.fragment_end;
  assign message_end_o  = res_q.message_end;
  assign status_o       = res_q.status;

`ifndef ASSERT_OFF
  // truncation is only reported on the last byte of a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> message_end_o)
    else $error("truncated status without message end");

  // a completed fragment is never reported as truncated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fragment_end_o |-> !status_o)
    else $error("fragment end together with truncated status");

  // only key bytes carry a key position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (key_position_o != '0) |-> byte_kind_o == KIND_KEY)
    else $error("key position on a non-key byte");

  // a key byte never completes a fragment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == KIND_KEY |-> !fragment_end_o)
    else $error("fragment end on a key byte");

  // a stalled input transaction waits only behind a full, stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && in_valid_q)
    else $error("input stalled while result side is free");
`endif

endmodule

`default_nettype wire
